/* design/crpe_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and field layout for the catmull-rom point evaluator
package crpe_pkg;

    // store and number formats
    localparam int MAX_POINTS_DEF = 256;
    localparam int FRAC_BITS      = 16;
    localparam int COORD_BITS     = 32;
    localparam int INDEX_W        = 8;
    localparam int SEG_W          = 8;
    localparam int CNT_W          = 9;
    localparam int LIM_W          = 32;

    // point store banking, index modulo four
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BADDR_W    = INDEX_W - BANK_SEL_W;

    localparam int NUM_TERMS = 4;
    localparam int NUM_AXES  = 3;

    // input tdata layout, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int X_LSB      = IDX_LSB + INDEX_W;
    localparam int Y_LSB      = X_LSB + COORD_BITS;
    localparam int Z_LSB      = Y_LSB + COORD_BITS;
    localparam int SEG_LSB    = Z_LSB + COORD_BITS;
    localparam int FRAC_LSB   = SEG_LSB + SEG_W;
    localparam int IN_FIELD_W = FRAC_LSB + 16;
    localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_AXES * COORD_BITS + 7) / 8) * 8;

    // datapath widths
    localparam int V_W    = FRAC_BITS + 1;
    localparam int UU_W   = 2 * FRAC_BITS;
    localparam int UV_W   = UU_W + 1;
    localparam int VV_W   = 2 * V_W;
    localparam int U3_W   = 3 * FRAC_BITS;
    localparam int W0M_W  = VV_W + FRAC_BITS;
    localparam int W3M_W  = UU_W + V_W;
    localparam int W_W    = 3 * FRAC_BITS + 3;
    localparam int WL_W   = (W_W - 1) / 2;
    localparam int WH_W   = W_W - WL_W;
    localparam int PP_W   = WH_W + COORD_BITS;
    localparam int ACC_W  = W_W + COORD_BITS + 2;
    localparam int SHIFT  = 3 * FRAC_BITS + 1;
    localparam int SH_W   = ACC_W - SHIFT;

    localparam logic [V_W-1:0]   S_VAL  = V_W'(1) << FRAC_BITS;
    localparam logic [W_W-1:0]   TWO_S3 = W_W'(2) << (3 * FRAC_BITS);
    localparam logic [ACC_W-1:0] RND    = ACC_W'(1) << (3 * FRAC_BITS);

    localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    // queues
    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 16;
    localparam int CREDIT_W    = $clog2(RES_Q_DEPTH + 1);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd_kind;

    typedef enum logic {
        ST_OK           = 1'b0,
        ST_OUT_OF_RANGE = 1'b1
    } t_status;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        t_cmd_kind                             kind;
        logic                                  oor;
        logic [BANK_SEL_W-1:0]                 wr_bank;
        logic [BADDR_W-1:0]                    wr_addr;
        logic [NUM_BANKS-1:0][BADDR_W-1:0]     rd_addr;
        logic [BANK_SEL_W-1:0]                 rot;
        logic [FRAC_BITS-1:0]                  frac;
        t_point                                pt;
    } t_cmd;

    typedef struct packed {
        t_status status;
        t_point  pt;
    } t_res;

endpackage

/* design/crpe_fifo.sv */
`timescale 1ns / 1ps
// small flop-based first-in first-out queue
module crpe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/crpe_front.sv */
`timescale 1ns / 1ps
// request intake: point count register, range check and bank address decode
module crpe_front #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [crpe_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [crpe_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic                              i_tuser,
    input  logic                              i_q_full,
    output logic                              o_push,
    output crpe_pkg::t_cmd                    o_cmd
);
    import crpe_pkg::*;

    logic [CNT_W-1:0]   r_point_count;
    logic [INDEX_W-1:0] w_idx;
    logic [SEG_W-1:0]   w_seg;
    logic [LIM_W-1:0]   w_limit;
    logic               w_drop;
    logic               w_accept;
    t_cmd_kind          w_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_point_count <= i_cfg_wr_data;
        end
    end

    assign o_tready = !i_q_full;
    assign w_accept = i_tvalid && o_tready;
    assign w_kind   = t_cmd_kind'(i_tuser);
    assign w_idx    = i_tdata[IDX_LSB +: INDEX_W];
    assign w_seg    = i_tdata[SEG_LSB +: SEG_W];

    // usable points are capped by the store size
    assign w_limit = (LIM_W'(r_point_count) >= LIM_W'(MAX_POINTS))
                   ? LIM_W'(MAX_POINTS) : LIM_W'(r_point_count);
    // writes past the store are dropped here
    assign w_drop  = (LIM_W'(w_idx) >= LIM_W'(MAX_POINTS));

    always_comb begin
        o_cmd.kind    = w_kind;
        o_cmd.oor     = ((LIM_W'(w_seg) + LIM_W'(3)) >= w_limit);
        o_cmd.wr_bank = w_idx[BANK_SEL_W-1:0];
        o_cmd.wr_addr = w_idx[INDEX_W-1:BANK_SEL_W];
        o_cmd.rot     = w_seg[BANK_SEL_W-1:0];
        o_cmd.frac    = i_tdata[FRAC_LSB +: FRAC_BITS];
        o_cmd.pt.x    = i_tdata[X_LSB +: COORD_BITS];
        o_cmd.pt.y    = i_tdata[Y_LSB +: COORD_BITS];
        o_cmd.pt.z    = i_tdata[Z_LSB +: COORD_BITS];
        // banks below the start bank hold points of the next row
        for (int b = 0; b < NUM_BANKS; b++) begin
            o_cmd.rd_addr[b] = w_seg[SEG_W-1:BANK_SEL_W]
                             + BADDR_W'(BANK_SEL_W'(b) < w_seg[BANK_SEL_W-1:0]);
        end
    end

    always_comb begin
        case (w_kind)
            CMD_WRITE: o_push = w_accept && !w_drop;
            CMD_EVAL:  o_push = w_accept;
            default:   o_push = 1'b0;
        endcase
    end

endmodule

/* design/crpe_back.sv */
`timescale 1ns / 1ps
// point store banks and the weight, multiply, sum and saturate pipeline
module crpe_back #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  crpe_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_res_pop,
    output logic            o_res_push,
    output crpe_pkg::t_res  o_res
);
    import crpe_pkg::*;

    localparam int DEPTH      = (MAX_POINTS < (1 << INDEX_W)) ? MAX_POINTS : (1 << INDEX_W);
    localparam int BANK_DEPTH = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // credit for result queue slots
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic                w_take, w_we, w_re;

    t_point r_mem [NUM_BANKS][BANK_DEPTH];
    t_point r_rd1 [NUM_BANKS];

    // stage 1
    logic                 r_v1, r_oor1;
    logic [BANK_SEL_W-1:0] r_rot1;
    logic [FRAC_BITS-1:0] r_u1;
    logic [V_W-1:0]       r_vv_1;
    logic [UU_W-1:0]      r_uu1;
    logic [VV_W-1:0]      r_vsq1;
    logic [FRAC_BITS-1:0] w_u;
    logic [V_W-1:0]       w_v;
    // stage 2
    logic                 r_v2, r_oor2;
    logic [FRAC_BITS-1:0] r_u2;
    logic [UU_W-1:0]      r_uu2;
    logic [U3_W-1:0]      r_u3_2;
    logic [W0M_W-1:0]     r_w0m2;
    logic [W3M_W-1:0]     r_w3m2;
    logic signed [COORD_BITS-1:0] r_p2 [NUM_AXES][NUM_TERMS];
    // stage 3
    logic                 r_v3, r_oor3;
    logic signed [W_W-1:0] r_w3 [NUM_TERMS];
    logic signed [COORD_BITS-1:0] r_p3 [NUM_AXES][NUM_TERMS];
    logic [W_W-1:0]       w_u3x3, w_uu5s, w_w1, w_w2;
    // stage 4
    logic                 r_v4, r_oor4;
    logic signed [PP_W-1:0] r_hp4 [NUM_AXES][NUM_TERMS];
    logic signed [PP_W-1:0] r_lp4 [NUM_AXES][NUM_TERMS];
    // stage 5
    logic                 r_v5, r_oor5;
    logic signed [ACC_W-1:0] r_t5 [NUM_AXES][NUM_TERMS];
    // stage 6
    logic                 r_v6, r_oor6;
    logic signed [ACC_W-1:0] r_sa6 [NUM_AXES];
    logic signed [ACC_W-1:0] r_sb6 [NUM_AXES];
    // stage 7
    logic                 r_v7, r_oor7;
    logic signed [ACC_W-1:0] r_sum7 [NUM_AXES];
    logic [COORD_BITS-1:0]   w_sat [NUM_AXES];
    logic [SH_W-1:0]         w_sh [NUM_AXES];

    // issue: a write always goes, an evaluation needs a free result slot
    assign o_cmd_pop = i_cmd_valid && ((i_cmd.kind == CMD_WRITE) || (r_credit != '0));
    assign w_take    = o_cmd_pop && (i_cmd.kind == CMD_EVAL);
    assign w_we      = o_cmd_pop && (i_cmd.kind == CMD_WRITE);
    assign w_re      = w_take && !i_cmd.oor;
    assign n_credit  = r_credit - CREDIT_W'(w_take) + CREDIT_W'(i_res_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CREDIT_W'(RES_Q_DEPTH);
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r_v1 <= w_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // point store, one write or a four-bank read per cycle
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (w_we && (i_cmd.wr_bank == BANK_SEL_W'(b))) begin
                r_mem[b][i_cmd.wr_addr[BA_W-1:0]] <= i_cmd.pt;
            end
            if (w_re) begin
                r_rd1[b] <= r_mem[b][i_cmd.rd_addr[b][BA_W-1:0]];
            end
        end
    end

    assign w_u = i_cmd.frac;
    assign w_v = S_VAL - V_W'(w_u);

    // stage 1: squares of t and 1-t
    always_ff @(posedge i_clk) begin
        r_oor1 <= i_cmd.oor;
        r_rot1 <= i_cmd.rot;
        r_u1   <= w_u;
        r_vv_1 <= w_v;
        r_uu1  <= UU_W'(w_u) * UU_W'(w_u);
        r_vsq1 <= VV_W'(w_v) * VV_W'(w_v);
    end

    // stage 2: cubes, and points rotated into curve order
    always_ff @(posedge i_clk) begin
        r_oor2 <= r_oor1;
        r_u2   <= r_u1;
        r_uu2  <= r_uu1;
        r_u3_2 <= U3_W'(r_uu1) * U3_W'(r_u1);
        r_w0m2 <= W0M_W'(r_vsq1) * W0M_W'(r_u1);
        r_w3m2 <= W3M_W'(r_uu1) * W3M_W'(r_vv_1);
        for (int k = 0; k < NUM_TERMS; k++) begin
            r_p2[0][k] <= r_rd1[BANK_SEL_W'(r_rot1 + BANK_SEL_W'(k))].x;
            r_p2[1][k] <= r_rd1[BANK_SEL_W'(r_rot1 + BANK_SEL_W'(k))].y;
            r_p2[2][k] <= r_rd1[BANK_SEL_W'(r_rot1 + BANK_SEL_W'(k))].z;
        end
    end

    // stage 3: basis weights at scale 2^(3*frac)
    always_comb begin
        w_u3x3 = (W_W'(r_u3_2) << 1) + W_W'(r_u3_2);
        w_uu5s = ((W_W'(r_uu2) << 2) + W_W'(r_uu2)) << FRAC_BITS;
        w_w1   = TWO_S3 - w_uu5s + w_u3x3;
        w_w2   = (W_W'(r_u2) << (2 * FRAC_BITS)) + (W_W'(r_uu2) << (FRAC_BITS + 2)) - w_u3x3;
    end

    always_ff @(posedge i_clk) begin
        r_oor3  <= r_oor2;
        r_w3[0] <= -$signed({1'b0, r_w0m2});
        r_w3[1] <= $signed(w_w1);
        r_w3[2] <= $signed(w_w2);
        r_w3[3] <= -$signed({2'b0, r_w3m2});
        r_p3    <= r_p2;
    end

    // stage 4: weight split in two halves, partial products
    always_ff @(posedge i_clk) begin
        r_oor4 <= r_oor3;
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_hp4[a][k] <= $signed(r_w3[k][W_W-1:WL_W]) * r_p3[a][k];
                r_lp4[a][k] <= $signed({1'b0, r_w3[k][WL_W-1:0]}) * r_p3[a][k];
            end
        end
    end

    // stage 5: full terms
    always_ff @(posedge i_clk) begin
        r_oor5 <= r_oor4;
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_t5[a][k] <= (ACC_W'(r_hp4[a][k]) <<< WL_W) + ACC_W'(r_lp4[a][k]);
            end
        end
    end

    // stage 6: pair sums, rounding constant folded in
    always_ff @(posedge i_clk) begin
        r_oor6 <= r_oor5;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_sa6[a] <= r_t5[a][0] + r_t5[a][1] + $signed(RND);
            r_sb6[a] <= r_t5[a][2] + r_t5[a][3];
        end
    end

    // stage 7: full sum
    always_ff @(posedge i_clk) begin
        r_oor7 <= r_oor6;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_sum7[a] <= r_sa6[a] + r_sb6[a];
        end
    end

    // halve and descale, then clamp to the coordinate range
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_sh[a] = r_sum7[a][ACC_W-1:SHIFT];
            if ((&w_sh[a][SH_W-1:COORD_BITS-1]) || !(|w_sh[a][SH_W-1:COORD_BITS-1])) begin
                w_sat[a] = w_sh[a][COORD_BITS-1:0];
            end else if (w_sh[a][SH_W-1]) begin
                w_sat[a] = SAT_MIN;
            end else begin
                w_sat[a] = SAT_MAX;
            end
        end
    end

    assign o_res_push = r_v7;

    always_comb begin
        if (r_oor7) begin
            o_res.status = ST_OUT_OF_RANGE;
            o_res.pt     = '0;
        end else begin
            o_res.status = ST_OK;
            o_res.pt.x   = w_sat[0];
            o_res.pt.y   = w_sat[1];
            o_res.pt.z   = w_sat[2];
        end
    end

endmodule

/* design/catmull_rom_point_eval_core.sv */
`timescale 1ns / 1ps
// top level of the uniform catmull-rom 3d point evaluator
//
// The block keeps up to min(MAX_POINTS, 256) control points in Q16.16 and
// evaluates uniform Catmull-Rom points from them. A request with tuser 0 stores
// one point at point_index and returns nothing; a request with tuser 1 evaluates
// segment/fraction over points segment..segment+3 and returns one result, with
// tuser 1 (out of range, coordinates zero) when segment+3 is not below the
// point count. Requests stream at one per cycle, writes and evaluations mixed
// in any order, as long as results are taken: at most sixteen evaluations may
// be in flight or waiting in the result queue, after which evaluations stop
// issuing and intake stalls once the four-entry command queue fills. A result
// is offered once its request has passed through the command queue, then
// seven pipeline registers (weight products, split 51x32 multiplies,
// two-level sum with rounding), then the clamp and the write into the result
// queue. The store is four banks interleaved by index modulo four, so the
// four points of any segment come out in one read; one write or one
// read per cycle. The store is not cleared at reset: evaluate only over points
// that were written. Program point_count while no request is outstanding.
module catmull_rom_point_eval_core #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // point count register
    input  logic                               i_cfg_wr_en,
    input  logic [crpe_pkg::CNT_W-1:0]         i_cfg_wr_data,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // point_index, coord_x, coord_y, coord_z, segment, fraction
    input  logic [crpe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // point_x, point_y, point_z
    output logic [crpe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status
    output logic                               m_axis_tuser
);
    import crpe_pkg::*;

    // front to command queue
    logic  w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    t_cmd  w_cmd_in, w_cmd_head;
    // back to result queue
    logic  w_res_push, w_res_full, w_res_empty, w_res_pop;
    t_res  w_res_in, w_res_head;

    // intake and classification
    crpe_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tvalid      (s_axis_tvalid),
        .o_tready      (s_axis_tready),
        .i_tdata       (s_axis_tdata),
        .i_tuser       (s_axis_tuser),
        .i_q_full      (w_cmd_full),
        .o_push        (w_cmd_push),
        .o_cmd         (w_cmd_in)
    );

    // decouples intake from the arithmetic path
    crpe_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_head),
        .o_empty (w_cmd_empty)
    );

    // point store and evaluation pipeline; evaluations issue only with a result slot reserved
    crpe_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_head),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_pop   (w_res_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // result queue doubles as the output register
    crpe_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (w_res_pop),
        .o_data  (w_res_head),
        .o_empty (w_res_empty)
    );

    assign m_axis_tvalid = !w_res_empty;
    assign w_res_pop     = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = OUT_TDATA_W'({w_res_head.pt.z, w_res_head.pt.y, w_res_head.pt.x});
    assign m_axis_tuser  = (w_res_head.status == ST_OUT_OF_RANGE);

    // credit accounting must never let the pipeline push into a full result queue
    a_res_no_overflow : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full
    ) else $error("result queue overflow");

    // the back end only takes a request that is really queued
    a_cmd_pop_valid : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty
    ) else $error("command queue popped while empty");

    // an out-of-range result carries zero coordinates
    a_oor_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0)
    ) else $error("out-of-range result with nonzero coordinates");

endmodule
